// ===== rtl/syb_pkg.sv =====
// ----------------------------------------------------------------------------
// syb_pkg: shared constants for the sphere and yawed box test
// Stage counts of the pipeline sections and the fixed-point constants of the
// sine and cosine series.
// ----------------------------------------------------------------------------
package syb_pkg;

   localparam int SC_STAGES  = 9;
   localparam int ROT_STAGES = 3;
   localparam int CLP_STAGES = 6;
   localparam int NUM_STAGES = SC_STAGES + ROT_STAGES + CLP_STAGES;

   localparam int FRAC_BITS    = 30;
   localparam int REC_SHIFT    = 36;
   localparam int RADIUS_WIDTH = 31;

   localparam logic [RADIUS_WIDTH-1:0] RADIUS_RESET = 31'd65536;

   localparam logic [30:0] Q30_ONE    = 31'h4000_0000;
   localparam logic [29:0] QUARTER_PI = 30'd843314857;
   localparam logic [29:0] OCT_FULL   = 30'h2000_0000;

   // ceil(2^36 / k): exact quotient for any 30-bit dividend
   localparam logic [33:0] REC_42 = 34'(((64'd1 << REC_SHIFT) + 64'd41) / 64'd42);
   localparam logic [33:0] REC_20 = 34'(((64'd1 << REC_SHIFT) + 64'd19) / 64'd20);
   localparam logic [33:0] REC_6  = 34'(((64'd1 << REC_SHIFT) + 64'd5) / 64'd6);
   localparam logic [33:0] REC_56 = 34'(((64'd1 << REC_SHIFT) + 64'd55) / 64'd56);
   localparam logic [33:0] REC_30 = 34'(((64'd1 << REC_SHIFT) + 64'd29) / 64'd30);
   localparam logic [33:0] REC_12 = 34'(((64'd1 << REC_SHIFT) + 64'd11) / 64'd12);

endpackage

// ===== rtl/syb_sincos.sv =====
// ----------------------------------------------------------------------------
// syb_sincos: pipelined yaw sine and cosine
// Octant fold, Horner series for sine and cosine with one multiply per
// stage, then octant mapping. Q2.30 results.
// ----------------------------------------------------------------------------
module syb_sincos #(
   parameter int ANGLE_WIDTH = 16
) (
   input  logic                          clock,
   input  logic [syb_pkg::SC_STAGES-1:0] adv,
   input  logic [ANGLE_WIDTH-1:0]        yaw,
   output logic signed [31:0]            sin_q,
   output logic signed [31:0]            cos_q
);

   function automatic logic [29:0] div_const(input logic [29:0] v, input logic [33:0] m);
      logic [63:0] p;
      p = 64'(v) * 64'(m);
      return 30'(p >> syb_pkg::REC_SHIFT);
   endfunction

   function automatic logic [29:0] mul_q30(input logic [29:0] a, input logic [30:0] b);
      logic [60:0] p;
      p = 61'(a) * 61'(b);
      return 30'(p >> syb_pkg::FRAC_BITS);
   endfunction

   logic [31:0] phase;
   logic [2:0]  oct_in;
   logic [29:0] frac_in;
   logic [59:0] xprod;
   logic [29:0] x_in;

   assign phase   = 32'(yaw) << (32 - ANGLE_WIDTH);
   assign oct_in  = phase[31:29];
   assign frac_in = oct_in[0] ? (syb_pkg::OCT_FULL - {1'b0, phase[28:0]})
                              : {1'b0, phase[28:0]};
   assign xprod   = 60'(frac_in) * 60'(syb_pkg::QUARTER_PI);
   assign x_in    = 30'(xprod >> 29);

   logic [29:0] s1_x_ff;
   logic [2:0]  s1_oct_ff;
   logic [29:0] s2_x_ff, s2_x2_ff;
   logic [2:0]  s2_oct_ff;
   logic [29:0] s3_x_ff, s3_x2_ff;
   logic [30:0] s3_t_ff, s3_u_ff;
   logic [2:0]  s3_oct_ff;
   logic [29:0] s4_x_ff, s4_x2_ff, s4_p_ff, s4_pc_ff;
   logic [2:0]  s4_oct_ff;
   logic [29:0] s5_x_ff, s5_x2_ff;
   logic [30:0] s5_t_ff, s5_u_ff;
   logic [2:0]  s5_oct_ff;
   logic [29:0] s6_x_ff, s6_x2_ff, s6_p_ff, s6_pc_ff;
   logic [2:0]  s6_oct_ff;
   logic [29:0] s7_x_ff, s7_x2_ff;
   logic [30:0] s7_t_ff, s7_u_ff;
   logic [2:0]  s7_oct_ff;
   logic [29:0] s8_s_ff, s8_pc_ff;
   logic [2:0]  s8_oct_ff;
   logic signed [31:0] sin_ff, cos_ff;

   logic [30:0] c_mag, rs_mag, rc_mag;
   logic        swap;

   assign c_mag  = syb_pkg::Q30_ONE - 31'(s8_pc_ff >> 1);
   assign swap   = s8_oct_ff[0] ^ s8_oct_ff[1];
   assign rs_mag = swap ? c_mag : {1'b0, s8_s_ff};
   assign rc_mag = swap ? {1'b0, s8_s_ff} : c_mag;

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         s1_x_ff   <= x_in;
         s1_oct_ff <= oct_in;
      end
      if (adv[1]) begin
         s2_x_ff   <= s1_x_ff;
         s2_x2_ff  <= mul_q30(s1_x_ff, {1'b0, s1_x_ff});
         s2_oct_ff <= s1_oct_ff;
      end
      if (adv[2]) begin
         s3_x_ff   <= s2_x_ff;
         s3_x2_ff  <= s2_x2_ff;
         s3_t_ff   <= syb_pkg::Q30_ONE - {1'b0, div_const(s2_x2_ff, syb_pkg::REC_42)};
         s3_u_ff   <= syb_pkg::Q30_ONE - {1'b0, div_const(s2_x2_ff, syb_pkg::REC_56)};
         s3_oct_ff <= s2_oct_ff;
      end
      if (adv[3]) begin
         s4_x_ff   <= s3_x_ff;
         s4_x2_ff  <= s3_x2_ff;
         s4_p_ff   <= mul_q30(s3_x2_ff, s3_t_ff);
         s4_pc_ff  <= mul_q30(s3_x2_ff, s3_u_ff);
         s4_oct_ff <= s3_oct_ff;
      end
      if (adv[4]) begin
         s5_x_ff   <= s4_x_ff;
         s5_x2_ff  <= s4_x2_ff;
         s5_t_ff   <= syb_pkg::Q30_ONE - {1'b0, div_const(s4_p_ff, syb_pkg::REC_20)};
         s5_u_ff   <= syb_pkg::Q30_ONE - {1'b0, div_const(s4_pc_ff, syb_pkg::REC_30)};
         s5_oct_ff <= s4_oct_ff;
      end
      if (adv[5]) begin
         s6_x_ff   <= s5_x_ff;
         s6_x2_ff  <= s5_x2_ff;
         s6_p_ff   <= mul_q30(s5_x2_ff, s5_t_ff);
         s6_pc_ff  <= mul_q30(s5_x2_ff, s5_u_ff);
         s6_oct_ff <= s5_oct_ff;
      end
      if (adv[6]) begin
         s7_x_ff   <= s6_x_ff;
         s7_x2_ff  <= s6_x2_ff;
         s7_t_ff   <= syb_pkg::Q30_ONE - {1'b0, div_const(s6_p_ff, syb_pkg::REC_6)};
         s7_u_ff   <= syb_pkg::Q30_ONE - {1'b0, div_const(s6_pc_ff, syb_pkg::REC_12)};
         s7_oct_ff <= s6_oct_ff;
      end
      if (adv[7]) begin
         s8_s_ff   <= mul_q30(s7_x_ff, s7_t_ff);
         s8_pc_ff  <= mul_q30(s7_x2_ff, s7_u_ff);
         s8_oct_ff <= s7_oct_ff;
      end
      if (adv[8]) begin
         sin_ff <= s8_oct_ff[2] ? -$signed(32'(rs_mag)) : $signed(32'(rs_mag));
         cos_ff <= (s8_oct_ff[2] ^ s8_oct_ff[1]) ? -$signed(32'(rc_mag))
                                                 : $signed(32'(rc_mag));
      end
   end

   assign sin_q = sin_ff;
   assign cos_q = cos_ff;

endmodule

// ===== rtl/syb_rotate.sv =====
// ----------------------------------------------------------------------------
// syb_rotate: exact yaw rotation of the sphere offset
// Split multiply of the offset by sine and cosine, combine, then floor the
// Q30 sum, in three stages.
// ----------------------------------------------------------------------------
module syb_rotate #(
   parameter int COORD_WIDTH = 32
) (
   input  logic                           clock,
   input  logic [syb_pkg::ROT_STAGES-1:0] adv,
   input  logic signed [COORD_WIDTH+1:0]  d_x,
   input  logic signed [COORD_WIDTH+1:0]  d_z,
   input  logic signed [31:0]             sin_q,
   input  logic signed [31:0]             cos_q,
   output logic signed [COORD_WIDTH+2:0]  rot_x,
   output logic signed [COORD_WIDTH+2:0]  rot_z
);

   localparam int DW  = COORD_WIDTH + 2;
   localparam int XW  = (DW > 31) ? DW : 31;
   localparam int AHW = XW - syb_pkg::FRAC_BITS;
   localparam int PW  = COORD_WIDTH + 3;
   localparam int HW  = AHW + 33;
   localparam int SW  = HW + 1;

   logic signed [XW-1:0]  xe, ze;
   logic signed [AHW-1:0] xh, zh;
   logic signed [30:0]    xl, zl;

   assign xe = XW'(d_x);
   assign ze = XW'(d_z);
   assign xh = xe[XW-1:syb_pkg::FRAC_BITS];
   assign zh = ze[XW-1:syb_pkg::FRAC_BITS];
   assign xl = {1'b0, xe[syb_pkg::FRAC_BITS-1:0]};
   assign zl = {1'b0, ze[syb_pkg::FRAC_BITS-1:0]};

   logic signed [AHW+31:0] xhc_ff, xhs_ff, zhc_ff, zhs_ff;
   logic signed [62:0]     xlc_ff, xls_ff, zlc_ff, zls_ff;
   logic signed [HW-1:0]   hx_ff, hz_ff;
   logic signed [63:0]     lx_ff, lz_ff;
   logic signed [PW-1:0]   rx_ff, rz_ff;

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         xhc_ff <= xh * cos_q;
         xhs_ff <= xh * sin_q;
         zhc_ff <= zh * cos_q;
         zhs_ff <= zh * sin_q;
         xlc_ff <= xl * cos_q;
         xls_ff <= xl * sin_q;
         zlc_ff <= zl * cos_q;
         zls_ff <= zl * sin_q;
      end
      if (adv[1]) begin
         hx_ff <= HW'(xhc_ff) - HW'(zhs_ff);
         hz_ff <= HW'(zhc_ff) + HW'(xhs_ff);
         lx_ff <= 64'(xlc_ff) - 64'(zls_ff);
         lz_ff <= 64'(zlc_ff) + 64'(xls_ff);
      end
      if (adv[2]) begin
         rx_ff <= PW'(SW'(hx_ff) + SW'(lx_ff >>> syb_pkg::FRAC_BITS));
         rz_ff <= PW'(SW'(hz_ff) + SW'(lz_ff >>> syb_pkg::FRAC_BITS));
      end
   end

   assign rot_x = rx_ff;
   assign rot_z = rz_ff;

endmodule

// ===== rtl/syb_clamp.sv =====
// ----------------------------------------------------------------------------
// syb_clamp: clamp to box, squared distance and radius compare
// Three axis lanes: clamp, gap, magnitude and far check, square, sum, final
// compare against the squared doubled radius.
// ----------------------------------------------------------------------------
module syb_clamp #(
   parameter int COORD_WIDTH = 32
) (
   input  logic                           clock,
   input  logic [syb_pkg::CLP_STAGES-1:0] adv,
   input  logic signed [COORD_WIDTH+2:0]  rot_x,
   input  logic signed [COORD_WIDTH+2:0]  rot_z,
   input  logic signed [COORD_WIDTH+1:0]  d_y,
   input  logic signed [COORD_WIDTH:0]    ext_x,
   input  logic signed [COORD_WIDTH:0]    ext_y,
   input  logic signed [COORD_WIDTH:0]    ext_z,
   input  logic [31:0]                    rd,
   input  logic [63:0]                    rd_sq,
   output logic                           hit
);

   localparam int PW = COORD_WIDTH + 3;
   localparam int QW = PW + 1;
   localparam int MW = (QW > 33) ? QW : 33;

   logic signed [PW-1:0] p_in [3];
   logic signed [PW-1:0] e_in [3];

   assign p_in[0] = rot_x;
   assign p_in[1] = PW'(d_y);
   assign p_in[2] = rot_z;
   assign e_in[0] = PW'(ext_x);
   assign e_in[1] = PW'(ext_y);
   assign e_in[2] = PW'(ext_z);

   logic signed [PW-1:0] t_ff [3];
   logic signed [PW-1:0] ne_ff [3];
   logic signed [PW-1:0] p_ff [3];
   logic signed [QW-1:0] dist_ff [3];
   logic [31:0]          mag_ff [3];
   logic [2:0]           far_ff;
   logic [63:0]          sq_ff [3];
   logic                 far4_ff, far5_ff;
   logic [65:0]          sum_ff;
   logic                 hit_ff;

   logic signed [QW-1:0] q_in [3];
   logic [QW-1:0]        mag_in [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         q_in[i]   = (t_ff[i] > ne_ff[i]) ? QW'(t_ff[i]) : QW'(ne_ff[i]);
         mag_in[i] = dist_ff[i][QW-1] ? QW'(-dist_ff[i]) : QW'(dist_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         if (adv[0]) begin
            t_ff[i]  <= (p_in[i] < e_in[i]) ? p_in[i] : e_in[i];
            ne_ff[i] <= -e_in[i];
            p_ff[i]  <= p_in[i];
         end
         if (adv[1]) begin
            dist_ff[i] <= q_in[i] - QW'(p_ff[i]);
         end
         if (adv[2]) begin
            mag_ff[i] <= 32'(mag_in[i]);
            far_ff[i] <= MW'(mag_in[i]) > MW'(rd);
         end
         if (adv[3]) begin
            sq_ff[i] <= 64'(mag_ff[i]) * 64'(mag_ff[i]);
         end
      end
      if (adv[3]) begin
         far4_ff <= |far_ff;
      end
      if (adv[4]) begin
         sum_ff  <= 66'(sq_ff[0]) + 66'(sq_ff[1]) + 66'(sq_ff[2]);
         far5_ff <= far4_ff;
      end
      if (adv[5]) begin
         hit_ff <= !far5_ff && (sum_ff <= 66'(rd_sq));
      end
   end

   assign hit = hit_ff;

endmodule

// ===== rtl/sphere_yaw_box_collision_test.sv =====
// ----------------------------------------------------------------------------
// sphere_yaw_box_collision_test: sphere against yaw-rotated box
// Streams one collision test per item and returns one hit flag per item.
// ----------------------------------------------------------------------------
// Takes one item per clock through 18 pipeline stages unless the output
// stalls; the hit flag of an item is valid once it reaches the last stage.
// The doubled box center offset and doubled half extents form ahead of the
// first stage, alongside the octant fold. Nine stages run the sine and cosine
// series (one multiply per stage), three stages rotate the offset, and six
// stages clamp, square, sum and compare against the squared doubled radius.
// Stalls collapse bubbles stage by stage; req_ready drops only when every
// stage holds an item and the output is not taken. The radius register is
// written through the csr channel, which is always ready, and must only
// change while no item is in flight.
module sphere_yaw_box_collision_test #(
   parameter int COORD_WIDTH = 32,
   parameter int ANGLE_WIDTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [COORD_WIDTH-1:0] req_center_x,
   input  logic signed [COORD_WIDTH-1:0] req_center_y,
   input  logic signed [COORD_WIDTH-1:0] req_center_z,
   input  logic signed [COORD_WIDTH-1:0] req_box_lo_x,
   input  logic signed [COORD_WIDTH-1:0] req_box_lo_y,
   input  logic signed [COORD_WIDTH-1:0] req_box_lo_z,
   input  logic signed [COORD_WIDTH-1:0] req_box_hi_x,
   input  logic signed [COORD_WIDTH-1:0] req_box_hi_y,
   input  logic signed [COORD_WIDTH-1:0] req_box_hi_z,
   input  logic [ANGLE_WIDTH-1:0]        req_yaw,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_hit,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [30:0]                   csr_sphere_radius
);

   localparam int SC  = syb_pkg::SC_STAGES;
   localparam int RT  = syb_pkg::ROT_STAGES;
   localparam int NS  = syb_pkg::NUM_STAGES;
   localparam int DW  = COORD_WIDTH + 2;
   localparam int EW  = COORD_WIDTH + 1;
   localparam logic signed [31:0] SC_ONE = 32'sh4000_0000;

   logic [NS-1:0] adv;
   logic [NS-1:0] valid_ff, valid_in;

   always_comb begin
      adv[NS-1] = !valid_ff[NS-1] || rsp_ready;
      for (int i = NS - 2; i >= 0; i--) begin
         adv[i] = !valid_ff[i] || adv[i+1];
      end
      valid_in = valid_ff;
      if (adv[0]) begin
         valid_in[0] = req_valid;
      end
      for (int i = 1; i < NS; i++) begin
         if (adv[i]) begin
            valid_in[i] = valid_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_ready = adv[0];
   assign rsp_valid = valid_ff[NS-1];

   logic [syb_pkg::RADIUS_WIDTH-1:0] radius_ff;
   logic [31:0]                      rd;
   logic [63:0]                      rd_sq_ff;

   assign csr_ready = 1'b1;
   assign rd        = {radius_ff, 1'b0};

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= syb_pkg::RADIUS_RESET;
      end else if (csr_valid) begin
         radius_ff <= csr_sphere_radius;
      end
   end

   always_ff @(posedge clock) begin
      rd_sq_ff <= 64'(rd) * 64'(rd);
   end

   logic signed [DW-1:0] d_x_in, d_y_in, d_z_in;
   logic signed [EW-1:0] e_x_in, e_y_in, e_z_in;

   assign d_x_in = DW'(req_center_x) + DW'(req_center_x) - DW'(req_box_lo_x)
                   - DW'(req_box_hi_x);
   assign d_y_in = DW'(req_center_y) + DW'(req_center_y) - DW'(req_box_lo_y)
                   - DW'(req_box_hi_y);
   assign d_z_in = DW'(req_center_z) + DW'(req_center_z) - DW'(req_box_lo_z)
                   - DW'(req_box_hi_z);
   assign e_x_in = EW'(req_box_hi_x) - EW'(req_box_lo_x);
   assign e_y_in = EW'(req_box_hi_y) - EW'(req_box_lo_y);
   assign e_z_in = EW'(req_box_hi_z) - EW'(req_box_lo_z);

   logic signed [DW-1:0] dx_ff [SC];
   logic signed [DW-1:0] dz_ff [SC];
   logic signed [DW-1:0] dy_ff [SC+RT];
   logic signed [EW-1:0] ex_ff [SC+RT];
   logic signed [EW-1:0] ey_ff [SC+RT];
   logic signed [EW-1:0] ez_ff [SC+RT];

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         dx_ff[0] <= d_x_in;
         dz_ff[0] <= d_z_in;
         dy_ff[0] <= d_y_in;
         ex_ff[0] <= e_x_in;
         ey_ff[0] <= e_y_in;
         ez_ff[0] <= e_z_in;
      end
      for (int i = 1; i < SC; i++) begin
         if (adv[i]) begin
            dx_ff[i] <= dx_ff[i-1];
            dz_ff[i] <= dz_ff[i-1];
         end
      end
      for (int i = 1; i < SC + RT; i++) begin
         if (adv[i]) begin
            dy_ff[i] <= dy_ff[i-1];
            ex_ff[i] <= ex_ff[i-1];
            ey_ff[i] <= ey_ff[i-1];
            ez_ff[i] <= ez_ff[i-1];
         end
      end
   end

   logic signed [31:0]            sc_sin, sc_cos;
   logic signed [COORD_WIDTH+2:0] rot_x, rot_z;

   syb_sincos #(
      .ANGLE_WIDTH(ANGLE_WIDTH)
   ) u_sincos (
      .clock (clock),
      .adv   (adv[SC-1:0]),
      .yaw   (req_yaw),
      .sin_q (sc_sin),
      .cos_q (sc_cos)
   );

   syb_rotate #(
      .COORD_WIDTH(COORD_WIDTH)
   ) u_rotate (
      .clock (clock),
      .adv   (adv[SC+RT-1:SC]),
      .d_x   (dx_ff[SC-1]),
      .d_z   (dz_ff[SC-1]),
      .sin_q (sc_sin),
      .cos_q (sc_cos),
      .rot_x (rot_x),
      .rot_z (rot_z)
   );

   syb_clamp #(
      .COORD_WIDTH(COORD_WIDTH)
   ) u_clamp (
      .clock (clock),
      .adv   (adv[NS-1:SC+RT]),
      .rot_x (rot_x),
      .rot_z (rot_z),
      .d_y   (dy_ff[SC+RT-1]),
      .ext_x (ex_ff[SC+RT-1]),
      .ext_y (ey_ff[SC+RT-1]),
      .ext_z (ez_ff[SC+RT-1]),
      .rd    (rd),
      .rd_sq (rd_sq_ff),
      .hit   (rsp_hit)
   );

   a_full_when_blocked : assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (&valid_ff))
      else $error("input blocked while a pipeline stage is empty");

   a_trig_range : assert property (@(posedge clock) disable iff (reset)
      valid_ff[SC-1] |-> (sc_sin >= -SC_ONE && sc_sin <= SC_ONE &&
                          sc_cos >= -SC_ONE && sc_cos <= SC_ONE))
      else $error("sine or cosine outside unit range");

endmodule

// ===== verif/sphere_yaw_box_collision_test_test.sv =====
// ----------------------------------------------------------------------------
// sphere_yaw_box_collision_test_test: self-checking bench for the sphere test
// Drives collision tests with random gaps, predicts each hit flag with an
// independent fixed-point model and checks results in order on the rsp side.
// ----------------------------------------------------------------------------
module sphere_yaw_box_collision_test_test;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic signed [31:0] c [3];
      logic signed [31:0] lo [3];
      logic signed [31:0] hi [3];
      logic [15:0]        yaw;
   } probe_type;

   class hit_scoreboard;
      bit      pending [$];
      int      errors;
      longint  radius;

      function new();
         errors = 0;
         radius = 65536;
      endfunction

      function longint fdiv(longint v, int n);
         if (v >= 0) return v >>> n;
         return -((~v) >>> n) - 1;
      endfunction

      function longint mix(longint a, longint c, longint b, longint s);
         longint ah, bh, al, bl;
         ah = fdiv(a, 30);
         bh = fdiv(b, 30);
         al = a - (ah <<< 30);
         bl = b - (bh <<< 30);
         return ah * c - bh * s + fdiv(al * c - bl * s, 30);
      endfunction

      function void trig(logic [15:0] yaw, output longint sn, output longint cs);
         longint unsigned ph, f, x, x2, t, u, s, c, one;
         int oct;
         one = 64'd1 << 30;
         ph = longint'(yaw) << 16;
         oct = int'(ph >> 29) & 7;
         f = ph & 64'h1FFF_FFFF;
         if (oct & 1) f = 64'h2000_0000 - f;
         x = (f * 64'd843314857) >> 29;
         x2 = (x * x) >> 30;
         t = one - x2 / 42;
         t = one - ((x2 * t) >> 30) / 20;
         t = one - ((x2 * t) >> 30) / 6;
         s = (x * t) >> 30;
         u = one - x2 / 56;
         u = one - ((x2 * u) >> 30) / 30;
         u = one - ((x2 * u) >> 30) / 12;
         c = one - ((x2 * u) >> 30) / 2;
         if ((oct + 1) & 2) begin
            sn = c; cs = s;
         end else begin
            sn = s; cs = c;
         end
         if (oct & 4) sn = -sn;
         if ((oct + 2) & 4) cs = -cs;
      endfunction

      function bit fits(longint p, longint e, longint unsigned rd,
                        inout longint unsigned rem);
         longint t, q, d;
         longint unsigned mag, sq;
         t = p < e ? p : e;
         q = t > -e ? t : -e;
         d = q - p;
         mag = d < 0 ? -d : d;
         if (mag > rd) return 0;
         sq = mag * mag;
         if (sq > rem) return 0;
         rem -= sq;
         return 1;
      endfunction

      function void note_test(probe_type p);
         longint d [3], e [3];
         longint sn, cs, rx, rz;
         longint unsigned rd, rem;
         bit h;
         for (int i = 0; i < 3; i++) begin
            d[i] = 2 * longint'(p.c[i]) - longint'(p.lo[i]) - longint'(p.hi[i]);
            e[i] = longint'(p.hi[i]) - longint'(p.lo[i]);
         end
         trig(p.yaw, sn, cs);
         rx = mix(d[0], cs, d[2], sn);
         rz = mix(d[2], cs, d[0], -sn);
         rd = 2 * radius;
         rem = rd * rd;
         h = fits(rx, e[0], rd, rem) && fits(d[1], e[1], rd, rem) &&
             fits(rz, e[2], rd, rem);
         pending.push_back(h);
      endfunction

      task report(string msg);
         $display("mismatch: %s", msg);
         errors++;
      endtask

      task check_hit(logic h);
         bit want;
         if (pending.size() == 0) begin
            report("hit with no test outstanding");
            return;
         end
         want = pending.pop_front();
         if (h !== want) report($sformatf("hit %b, predicted %b", h, want));
      endtask
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0, req_ready;
   logic signed [31:0] req_center_x = 0, req_center_y = 0, req_center_z = 0;
   logic signed [31:0] req_box_lo_x = 0, req_box_lo_y = 0, req_box_lo_z = 0;
   logic signed [31:0] req_box_hi_x = 0, req_box_hi_y = 0, req_box_hi_z = 0;
   logic [15:0] req_yaw = 0;
   logic rsp_valid, rsp_ready = 0, rsp_hit;
   logic csr_valid = 0, csr_ready;
   logic [30:0] csr_sphere_radius = 0;

   hit_scoreboard board = new();
   longint cycles = 0;
   bit driving = 1;

   always #1 clock = ~clock;

   sphere_yaw_box_collision_test u_dut (.*);

   function int gap();
      if ($urandom_range(0, 9) < 3) return 0;
      if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
      return $urandom_range(1, 3);
   endfunction

   function logic signed [31:0] coord(int mode);
      case (mode)
         0: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
         1: return $signed($urandom());
         default: return $signed($urandom_range(0, 20 << 16)) - (10 << 16);
      endcase
   endfunction

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 400000) begin
         $display("sphere_yaw_box_collision_test_test: done, errors");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) board.check_hit(rsp_hit);
         if (!driving) rsp_ready <= 1;
         else if ($urandom_range(0, 49) == 0) rsp_ready <= 0;
         else if ($urandom_range(0, 3) == 0) rsp_ready <= ~rsp_ready;
         else rsp_ready <= 1;
      end
   end

   task automatic send_test(probe_type p);
      int g;
      g = gap();
      if ($urandom_range(0, 1)) g = 0;
      if (g != 0) begin
         req_valid <= 0;
         repeat (g) @(posedge clock);
      end
      req_valid <= 1;
      req_center_x <= p.c[0]; req_center_y <= p.c[1]; req_center_z <= p.c[2];
      req_box_lo_x <= p.lo[0]; req_box_lo_y <= p.lo[1]; req_box_lo_z <= p.lo[2];
      req_box_hi_x <= p.hi[0]; req_box_hi_y <= p.hi[1]; req_box_hi_z <= p.hi[2];
      req_yaw <= p.yaw;
      do @(posedge clock); while (!req_ready);
      board.note_test(p);
   endtask

   task automatic write_radius(logic [30:0] r);
      req_valid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (syb_pkg::NUM_STAGES + 4) @(posedge clock);
      csr_valid <= 1;
      csr_sphere_radius <= r;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      board.radius = r;
   endtask

   task automatic random_test(int mode);
      probe_type p;
      int m;
      for (int i = 0; i < 3; i++) begin
         m = mode == 1 ? $urandom_range(0, 2) : mode;
         p.c[i] = coord(m);
         p.lo[i] = coord(m);
         p.hi[i] = $urandom_range(0, 9) == 0 ? coord(m) :
                   p.lo[i] + $signed($urandom_range(0, 6 << 16));
         if (mode == 2 && $urandom_range(0, 1))
            p.c[i] = p.lo[i] + $signed($urandom_range(0, 8 << 16)) - (1 << 16);
      end
      p.yaw = 16'($urandom());
      send_test(p);
   endtask

   initial begin
      probe_type p;
      logic [30:0] radii [5];
      radii = '{31'd0, 31'h7FFF_FFFF, 31'd65536, 31'd131072, 31'd32768};
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      for (int k = 0; k < 16; k++) begin
         for (int i = 0; i < 3; i++) begin
            p.c[i] = 0; p.lo[i] = -(1 << 16); p.hi[i] = 1 << 16;
         end
         p.yaw = 16'(k * 4096 + (k & 1));
         p.c[0] = (k & 2) ? 32'sh0002_0000 : 32'sh0001_8000;
         if (k == 3) begin p.lo[0] = 1 << 16; p.hi[0] = -(1 << 16); end
         if (k == 5) begin p.c = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF}; end
         if (k == 6) begin p.lo = '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000};
            p.hi = '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF}; end
         if (k == 7) p.yaw = 16'hFFFF;
         if (k == 9) p.c[1] = 32'sh0005_0000;
         send_test(p);
      end
      for (int ph = 0; ph < 5; ph++) begin
         write_radius(radii[ph]);
         for (int n = 0; n < 210; n++)
            random_test(n % 10 == 0 ? 0 : (n % 3 == 0 ? 1 : 2));
      end
      req_valid <= 0;
      driving = 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (syb_pkg::NUM_STAGES + 10) @(posedge clock);
      if (board.errors == 0)
         $display("sphere_yaw_box_collision_test_test: done, clean");
      else
         $display("sphere_yaw_box_collision_test_test: done, errors");
      $finish;
   end
endmodule
